// ----- hw/rtl/per_type_latency_stats_table_macros.svh -----
// Assertion helpers for the statistics table
`ifndef PER_TYPE_LATENCY_STATS_TABLE_MACROS_SVH
`define PER_TYPE_LATENCY_STATS_TABLE_MACROS_SVH
`define PTLS_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("label");
`define PTLS_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("label");
`endif

// ----- hw/rtl/ptls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptls_pkg
// Shared types and constants of the per-type statistics table.
// ----------------------------------------------------------------------------
package ptls_pkg;
  localparam int NumTypesDefault = 64;
  localparam int DurW = 31;
  localparam int CntW = 32;
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]      op;
    logic [5:0]      type_id;
    logic [DurW-1:0] dur;
    logic            failed;
  } cmd_t;
endpackage

// ----- hw/rtl/ptls_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptls_divider
// Restoring divider: 64-bit dividend by 33-bit divisor, one quotient bit per
// cycle; returns the low 31 bits of the quotient.
// ----------------------------------------------------------------------------
module ptls_divider
  import ptls_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  logic [63:0]     dividend,
  input  logic [32:0]     divisor,
  output logic            done,
  output logic [DurW-1:0] quot
);
  logic [63:0] q;
  logic [33:0] rem;
  logic [32:0] dsr;
  logic [6:0]  cnt;
  logic        run;
  logic [33:0] shifted;
  logic [34:0] diff;

  assign shifted = {rem[32:0], q[63]};
  assign diff    = {1'b0, shifted} - {2'b0, dsr};
  assign quot    = q[DurW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        q   <= dividend;
        rem <= '0;
        dsr <= divisor;
      end else if (run) begin
        if (!diff[34]) begin
          rem <= diff[33:0];
          q   <= {q[62:0], 1'b1};
        end else begin
          rem <= shifted;
          q   <= {q[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hw/rtl/ptls_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptls_front
// Command intake: takes a transaction and queues it (two slots, at most one
// occupied, since busy is set while any entry is queued) for the back end.
// ----------------------------------------------------------------------------
module ptls_front
  import ptls_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [1:0]      op,
  input  logic [5:0]      type_id,
  input  logic [DurW-1:0] duration_ms,
  input  logic            sample_failed,
  output logic            busy,
  output logic            q_valid,
  output cmd_t            q_cmd,
  input  logic            q_pop
);
  cmd_t       slots [2];
  logic [0:0] wr_ptr;
  logic [0:0] rd_ptr;
  logic [1:0] fill;
  logic       push;

  assign busy    = (fill != 2'd0);
  assign push    = start && !busy;
  assign q_valid = (fill != 2'd0);
  assign q_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= '{op: op, type_id: type_id, dur: duration_ms,
                           failed: sample_failed};
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop && q_valid) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {1'b0, push} - {1'b0, q_pop && q_valid};
    end
  end
endmodule

// ----- hw/rtl/ptls_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptls_back
// Executes queued commands against the statistics memory and drives results.
// ----------------------------------------------------------------------------
module ptls_back
  import ptls_pkg::*;
#(
  parameter int NUM_TYPES = NumTypesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            stats_enable,
  input  logic            q_valid,
  input  cmd_t            q_cmd,
  output logic            q_pop,
  output logic            idle,
  output logic            done,
  output logic            applied,
  output logic            has_data,
  output logic [CntW-1:0] sample_count,
  output logic [CntW-1:0] success_count,
  output logic [CntW-1:0] failure_count,
  output logic [DurW-1:0] mean_ms,
  output logic [DurW-1:0] min_ms,
  output logic [DurW-1:0] max_ms
);
  localparam int IdxW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
  localparam int EntW = 3 * CntW + 3 * DurW;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_DIV, S_WB} state_t;
  state_t state;

  logic [EntW-1:0]      mem [NUM_TYPES];
  logic [NUM_TYPES-1:0] valid;
  logic [EntW-1:0]      rd;
  cmd_t                 cmd;
  logic                 in_range;
  logic [IdxW-1:0]      idx;
  logic [CntW-1:0]      n, okc, flc;
  logic [DurW-1:0]      mn, lo, hi;
  logic [63:0]          prod;
  logic                 div_go, div_done;
  logic [DurW-1:0]      quot;

  assign in_range = ({26'b0, cmd.type_id} < 32'(NUM_TYPES));
  assign idx      = IdxW'(cmd.type_id);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign idle     = (state == S_IDLE) && !q_valid;

  ptls_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(prod),
    .divisor({1'b0, n} + 33'd1), .done(div_done), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) rd <= mem[IdxW'(q_cmd.type_id)];
    if (state == S_WB) mem[idx] <= {n, okc, flc, mn, lo, hi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      done   <= 1'b0;
      div_go <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_cmd;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (cmd.op == OP_CLEAR) begin
            valid    <= '0;
            applied  <= 1'b1;
            has_data <= 1'b0;
            {sample_count, success_count, failure_count, mean_ms, min_ms, max_ms} <= '0;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else if (cmd.op == OP_ADD && stats_enable && in_range) begin
            if (valid[idx]) begin
              {n, okc, flc, mn, lo, hi} <= rd;
            end else begin
              {n, okc, flc, mn} <= '0;
              lo <= cmd.dur;
              hi <= cmd.dur;
            end
            state <= S_MUL;
          end else if (cmd.op == OP_ADD || cmd.op == OP_READ) begin
            applied <= 1'b0;
            if (in_range && valid[idx]) begin
              has_data <= 1'b1;
              {sample_count, success_count, failure_count, mean_ms, min_ms, max_ms} <= rd;
            end else begin
              has_data <= 1'b0;
              {sample_count, success_count, failure_count, mean_ms, min_ms, max_ms} <= '0;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            applied  <= 1'b0;
            has_data <= 1'b0;
            {sample_count, success_count, failure_count, mean_ms, min_ms, max_ms} <= '0;
            done     <= 1'b1;
            state    <= S_IDLE;
          end
        end
        S_MUL: begin
          prod   <= 64'(mn) * 64'(n) + 64'(cmd.dur);
          div_go <= 1'b1;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mn <= quot;
            if (cmd.dur < lo) lo <= cmd.dur;
            if (cmd.dur > hi) hi <= cmd.dur;
            if (n != '1) n <= n + 1'b1;
            if (cmd.failed) begin
              if (flc != '1) flc <= flc + 1'b1;
            end else begin
              if (okc != '1) okc <= okc + 1'b1;
            end
            state <= S_WB;
          end
        end
        S_WB: begin
          valid[idx]    <= 1'b1;
          applied       <= 1'b1;
          has_data      <= 1'b1;
          sample_count  <= n;
          success_count <= okc;
          failure_count <= flc;
          mean_ms       <= mn;
          min_ms        <= lo;
          max_ms        <= hi;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/per_type_latency_stats_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_type_latency_stats_table
// Per-type duration statistics: counts, running mean, minimum and maximum.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  command  | start / busy          | op, type_id, duration_ms, sample_failed
//  result   | done (one cycle)      | applied .. max_ms
//  config   | APB write, paddr 0    | stats_enable
// An add that updates passes through read, multiply, the 64-step divider
// and write-back; reads, clears, ignored adds and op three end in the read
// state. busy holds while a transaction is queued. Reset is synchronous;
// the table is empty after it. Results cannot be stalled.
module per_type_latency_stats_table
  import ptls_pkg::*;
#(
  parameter int NUM_TYPES = NumTypesDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      op,
  input  logic [5:0]      type_id,
  input  logic [DurW-1:0] duration_ms,
  input  logic            sample_failed,
  output logic            done,
  output logic            applied,
  output logic            has_data,
  output logic [CntW-1:0] sample_count,
  output logic [CntW-1:0] success_count,
  output logic [CntW-1:0] failure_count,
  output logic [DurW-1:0] mean_ms,
  output logic [DurW-1:0] min_ms,
  output logic [DurW-1:0] max_ms,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [0:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  logic stats_enable, q_valid, q_pop, idle;
  cmd_t q_cmd;

  assign pready = 1'b1;
  assign prdata = {31'b0, stats_enable};

  always_ff @(posedge clk) begin
    if (rst) stats_enable <= 1'b1;
    else if (psel && penable && pwrite && paddr == 1'b0) stats_enable <= pwdata[0];
  end

  ptls_front u_front (
    .clk(clk), .rst(rst), .start(start), .op(op), .type_id(type_id),
    .duration_ms(duration_ms), .sample_failed(sample_failed), .busy(busy),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  ptls_back #(.NUM_TYPES(NUM_TYPES)) u_back (
    .clk(clk), .rst(rst), .stats_enable(stats_enable), .q_valid(q_valid),
    .q_cmd(q_cmd), .q_pop(q_pop), .idle(idle), .done(done), .applied(applied),
    .has_data(has_data), .sample_count(sample_count), .success_count(success_count),
    .failure_count(failure_count), .mean_ms(mean_ms), .min_ms(min_ms),
    .max_ms(max_ms)
  );

`include "per_type_latency_stats_table_macros.svh"
  `PTLS_ASSERT_IMP(a_done_not_idle_start, done, !idle || !busy)
  `PTLS_ASSERT_IMP(a_data_no_applied_clear, done && has_data, sample_count != 32'd0)
  `PTLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
endmodule

// ----- test/per_type_latency_stats_table_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_type_latency_stats_table_test
// Self-checking bench for the per-type statistics table. Commands are queued,
// driven over start/busy with random idle gaps, and every done strobe is
// compared field by field with a predicted entry kept alongside the table.
// ----------------------------------------------------------------------------
module per_type_latency_stats_table_test;
  import ptls_pkg::*;

  localparam int NTypes   = 64;
  localparam int WdLimit  = 5000;
  localparam int Settle   = 100;
  localparam logic [0:0] REG_STATS_ENABLE = 1'b0;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic            applied;
    logic            has_data;
    logic [CntW-1:0] cnt;
    logic [CntW-1:0] ok;
    logic [CntW-1:0] fail;
    logic [DurW-1:0] mean;
    logic [DurW-1:0] mn;
    logic [DurW-1:0] mx;
  } entry_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] op = OP_READ;
  logic [5:0] type_id = '0;
  logic [DurW-1:0] duration_ms = '0;
  logic sample_failed = 1'b0;
  logic applied, has_data;
  logic [CntW-1:0] sample_count, success_count, failure_count;
  logic [DurW-1:0] mean_ms, min_ms, max_ms;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  per_type_latency_stats_table dut (.*);

  always #5 clk = ~clk;

  // shadow of the table
  logic            stats_on = 1'b1;
  logic            tbl_valid [NTypes];
  logic [CntW-1:0] tbl_cnt [NTypes];
  logic [CntW-1:0] tbl_ok [NTypes];
  logic [CntW-1:0] tbl_fail [NTypes];
  logic [DurW-1:0] tbl_mean [NTypes];
  logic [DurW-1:0] tbl_min [NTypes];
  logic [DurW-1:0] tbl_max [NTypes];

  cmd_t        pending_cmds[$];
  entry_view_t expected_views[$];
  int idle_pct = 0;
  int mismatches = 0;
  int n_cmds = 0, n_results = 0, n_adds = 0, n_clears = 0;
  int quiet_cycles = 0;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic entry_view_t apply_cmd(cmd_t c);
    entry_view_t r;
    logic [63:0] sum;
    int i;
    r = '0;
    i = c.type_id;
    if (c.op == OP_CLEAR) begin
      for (int k = 0; k < NTypes; k++) tbl_valid[k] = 1'b0;
      r.applied = 1'b1;
      return r;
    end
    if (c.op == OP_NONE) return r;
    if (c.op == OP_ADD && stats_on) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_cnt[i] = '0;
        tbl_ok[i] = '0;
        tbl_fail[i] = '0;
        tbl_mean[i] = '0;
        tbl_min[i] = c.dur;
        tbl_max[i] = c.dur;
      end
      sum = 64'(tbl_mean[i]) * 64'(tbl_cnt[i]) + 64'(c.dur);
      tbl_mean[i] = DurW'(sum / (64'(tbl_cnt[i]) + 64'd1));
      if (c.dur < tbl_min[i]) tbl_min[i] = c.dur;
      if (c.dur > tbl_max[i]) tbl_max[i] = c.dur;
      tbl_cnt[i] = sat_inc(tbl_cnt[i]);
      if (c.failed) tbl_fail[i] = sat_inc(tbl_fail[i]);
      else tbl_ok[i] = sat_inc(tbl_ok[i]);
      r.applied = 1'b1;
    end
    if (tbl_valid[i]) begin
      r.has_data = 1'b1;
      r.cnt = tbl_cnt[i];
      r.ok = tbl_ok[i];
      r.fail = tbl_fail[i];
      r.mean = tbl_mean[i];
      r.mn = tbl_min[i];
      r.mx = tbl_max[i];
    end
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    logic nxt_start;
    cmd_t c;
    nxt_start = start;
    if (!rst) begin
      if (start && !busy) begin
        expected_views.push_back(apply_cmd({op, type_id, duration_ms, sample_failed}));
        n_cmds++;
        nxt_start = 1'b0;
      end
      if (!nxt_start && pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
        c = pending_cmds.pop_front();
        op <= c.op;
        type_id <= c.type_id;
        duration_ms <= c.dur;
        sample_failed <= c.failed;
        nxt_start = 1'b1;
      end
    end
    start <= nxt_start;
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    entry_view_t e;
    if (!rst && done) begin
      n_results++;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with nothing outstanding", $realtime);
      end else begin
        e = expected_views.pop_front();
        check_field("applied", e.applied, applied);
        check_field("has_data", e.has_data, has_data);
        check_field("sample_count", e.cnt, sample_count);
        check_field("success_count", e.ok, success_count);
        check_field("failure_count", e.fail, failure_count);
        check_field("mean_ms", e.mean, mean_ms);
        check_field("min_ms", e.mn, min_ms);
        check_field("max_ms", e.mx, max_ms);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WdLimit) begin
      $display("Timeout after %0d quiet cycles", quiet_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_cmd(logic [1:0] o, logic [5:0] t, logic [DurW-1:0] d, logic f);
    cmd_t c;
    c.op = o;
    c.type_id = t;
    c.dur = d;
    c.failed = f;
    if (o == OP_ADD) n_adds++;
    if (o == OP_CLEAR) n_clears++;
    pending_cmds.push_back(c);
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start && expected_views.size() == 0);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic write_enable(logic v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_STATS_ENABLE;
    pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    stats_on = v;
  endtask

  function automatic logic [DurW-1:0] rand_dur();
    case ($urandom_range(3))
      0: return DurW'($urandom_range(1000));
      1: return DurW'($urandom);
      2: return $urandom_range(1) ? '1 : '0;
      default: return DurW'($urandom_range(100000));
    endcase
  endfunction

  task automatic random_cmds(int n);
    int r;
    logic [5:0] t;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      // focus on a few entries so counts and means build up
      t = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
      if (r < 70) push_cmd(OP_ADD, t, rand_dur(), 1'($urandom));
      else if (r < 92) push_cmd(OP_READ, t, rand_dur(), 1'($urandom));
      else if (r < 96) push_cmd(OP_CLEAR, t, rand_dur(), 1'($urandom));
      else push_cmd(OP_NONE, t, rand_dur(), 1'($urandom));
    end
  endtask

  initial begin
    for (int k = 0; k < NTypes; k++) tbl_valid[k] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty reads, extremes, first sample, op three, clear, disabled adds
    push_cmd(OP_READ, 6'd63, '1, 1'b1);
    push_cmd(OP_ADD, 6'd0, '0, 1'b0);
    push_cmd(OP_ADD, 6'd0, '1, 1'b1);
    push_cmd(OP_ADD, 6'd0, 31'd5, 1'b0);
    push_cmd(OP_READ, 6'd0, '0, 1'b0);
    push_cmd(OP_ADD, 6'd63, '1, 1'b0);
    push_cmd(OP_ADD, 6'd63, '1, 1'b1);
    push_cmd(OP_NONE, 6'd0, '1, 1'b1);
    push_cmd(OP_CLEAR, 6'd63, '0, 1'b0);
    push_cmd(OP_READ, 6'd0, '0, 1'b0);
    push_cmd(OP_ADD, 6'd0, 31'd7, 1'b1);
    push_cmd(OP_ADD, 6'd42, 31'h2AAA_AAAA, 1'b0);
    push_cmd(OP_ADD, 6'd21, 31'h5555_5555, 1'b1);
    drain();
    write_enable(1'b0);
    push_cmd(OP_ADD, 6'd0, 31'd1, 1'b0);
    push_cmd(OP_ADD, 6'd5, 31'd9, 1'b1);
    push_cmd(OP_READ, 6'd0, '0, 1'b0);
    push_cmd(OP_CLEAR, 6'd0, '0, 1'b0);
    push_cmd(OP_READ, 6'd42, '0, 1'b0);
    drain();
    write_enable(1'b1);

    random_cmds(200);
    drain();
    idle_pct = 72;
    random_cmds(200);
    drain();
    idle_pct = 16;
    write_enable(1'b0);
    random_cmds(100);
    drain();
    write_enable(1'b1);
    random_cmds(200);
    drain();
    idle_pct = 0;
    random_cmds(100);
    drain();

    $display("Ran %0d commands (%0d adds, %0d clears), %0d results checked,",
             n_cmds, n_adds, n_clears, n_results);
    $display("with statistics enabled and disabled and sender gaps of 0, 16 and 72 percent.");
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
